// ----- rtl/core/tlptm_pkg.sv -----
// shared types, constants and helpers for the two-level page table mapper
`default_nettype none

package tlptm_pkg;

    localparam int FRAME_W          = 20;
    localparam int IDX_W            = 10;
    localparam int WORD_W           = 32;
    localparam int PAGE_SHIFT       = 12;
    localparam int CMD_W            = 2;
    localparam int STATUS_W         = 2;
    localparam int CFG_IDX_W        = 1;
    localparam int STORE_PAGES      = 64;
    localparam int ENTRIES_PER_PAGE = 1024;
    localparam int STORE_WORDS      = STORE_PAGES * ENTRIES_PER_PAGE;
    localparam int OFF_W            = $clog2(STORE_PAGES);
    localparam int ADDR_W           = OFF_W + IDX_W;
    localparam int FLAG_PAD_W       = PAGE_SHIFT - 3;

    localparam logic [FRAME_W-1:0] WINDOW_BASE_RST = FRAME_W'(39);
    localparam logic [FRAME_W-1:0] ALLOC_START_RST = FRAME_W'(48);

    typedef enum logic [CMD_W-1:0] {
        CMD_MAP,
        CMD_UNMAP,
        CMD_ALLOC,
        CMD_CLR_DIR
    } t_cmd;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK,
        ST_OUTSIDE,
        ST_NO_FREE,
        ST_ABSENT
    } t_status;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_WINDOW_BASE,
        CFG_ALLOC_START
    } t_cfg_idx;

    typedef enum logic [1:0] {
        WR_NONE,
        WR_CLEAR,
        WR_PDE,
        WR_PTE
    } t_wr_sel;

    typedef enum logic [2:0] {
        S_IDLE,
        S_EVAL,
        S_PDE,
        S_CLR_TBL,
        S_WR_PDE,
        S_PTE,
        S_CLR_DIR,
        S_FINISH
    } t_state;

    // controller to datapath
    typedef struct packed {
        logic    load_in;
        logic    rd_pde;
        logic    take_frame;
        logic    set_new;
        logic    tbl_from_pde;
        logic    clr_start;
        logic    clr_sel_tbl;
        t_wr_sel wr;
        logic    out_load;
        t_status out_status;
        logic    out_frame;
        logic    out_entry;
    } t_dp_cmd;

    // datapath to controller
    typedef struct packed {
        t_cmd cmd;
        logic dir_ok;
        logic free_ok;
        logic pde_present;
        logic tbl_ok;
        logic clr_last;
        logic out_busy;
    } t_dp_stat;

    function automatic logic [FRAME_W:0] frame_diff(input logic [FRAME_W-1:0] frame,
                                                    input logic [FRAME_W-1:0] base);
        frame_diff = {1'b0, frame} - {1'b0, base};
    endfunction

    // frame in window: subtract did not borrow, offset below STORE_PAGES
    function automatic logic in_window(input logic [FRAME_W:0] diff);
        in_window = !diff[FRAME_W] && (diff[FRAME_W-1:0] < FRAME_W'(STORE_PAGES));
    endfunction

    function automatic logic [WORD_W-1:0] make_entry(input logic [FRAME_W-1:0] frame,
                                                     input logic us,
                                                     input logic rw);
        make_entry = {frame, {FLAG_PAD_W{1'b0}}, us, rw, 1'b1};
    endfunction

endpackage

`default_nettype wire

// ----- rtl/core/tlptm_if.sv -----
// channel interfaces: command input, result output, configuration write
`default_nettype none

interface tlptm_in_if;
    logic                              valid;
    logic                              ready;
    logic [tlptm_pkg::CMD_W-1:0]       cmd;
    logic [tlptm_pkg::WORD_W-1:0]      dir_addr;
    logic [tlptm_pkg::WORD_W-1:0]      virt_addr;
    logic [tlptm_pkg::WORD_W-1:0]      phys_addr;
    logic                              user;
    logic                              writable;

    modport source (output valid, cmd, dir_addr, virt_addr, phys_addr, user, writable,
                    input ready);
    modport sink   (input valid, cmd, dir_addr, virt_addr, phys_addr, user, writable,
                    output ready);
endinterface

interface tlptm_out_if;
    logic                              valid;
    logic                              ready;
    logic [tlptm_pkg::STATUS_W-1:0]    status;
    logic [tlptm_pkg::FRAME_W-1:0]     frame_out;
    logic                              new_table;
    logic [tlptm_pkg::WORD_W-1:0]      entry_word;

    modport source (output valid, status, frame_out, new_table, entry_word, input ready);
    modport sink   (input valid, status, frame_out, new_table, entry_word, output ready);
endinterface

interface tlptm_cfg_if;
    logic                              valid;
    logic                              ready;
    logic [tlptm_pkg::CFG_IDX_W-1:0]   idx;
    logic [tlptm_pkg::FRAME_W-1:0]     data;

    modport source (output valid, idx, data, input ready);
    modport sink   (input valid, idx, data, output ready);
endinterface

`default_nettype wire

// ----- rtl/core/tlptm_dp.sv -----
// datapath: page store, allocator, configuration registers and result register
`default_nettype none

module tlptm_dp (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire tlptm_pkg::t_dp_cmd              i_cmd,
    output tlptm_pkg::t_dp_stat                  o_stat,
    input  wire logic [tlptm_pkg::CMD_W-1:0]     i_in_cmd,
    input  wire logic [tlptm_pkg::WORD_W-1:0]    i_in_dir_addr,
    input  wire logic [tlptm_pkg::WORD_W-1:0]    i_in_virt_addr,
    input  wire logic [tlptm_pkg::WORD_W-1:0]    i_in_phys_addr,
    input  wire logic                            i_in_user,
    input  wire logic                            i_in_writable,
    input  wire logic                            i_cfg_valid,
    output logic                                 o_cfg_ready,
    input  wire logic [tlptm_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  wire logic [tlptm_pkg::FRAME_W-1:0]   i_cfg_data,
    output logic                                 o_out_valid,
    input  wire logic                            i_out_ready,
    output logic [tlptm_pkg::STATUS_W-1:0]       o_out_status,
    output logic [tlptm_pkg::FRAME_W-1:0]        o_out_frame,
    output logic                                 o_out_new_table,
    output logic [tlptm_pkg::WORD_W-1:0]         o_out_entry
);

    logic [tlptm_pkg::WORD_W-1:0]   r_mem [tlptm_pkg::STORE_WORDS];
    logic [tlptm_pkg::WORD_W-1:0]   r_rd_data;

    logic [tlptm_pkg::FRAME_W-1:0]  r_window_base;
    logic [tlptm_pkg::FRAME_W-1:0]  r_next_free;

    tlptm_pkg::t_cmd                r_cmd;
    logic [tlptm_pkg::FRAME_W-1:0]  r_dir_frame;
    logic [tlptm_pkg::IDX_W-1:0]    r_pd_idx;
    logic [tlptm_pkg::IDX_W-1:0]    r_pt_idx;
    logic [tlptm_pkg::FRAME_W-1:0]  r_phys_frame;
    logic                           r_us;
    logic                           r_rw;
    logic [tlptm_pkg::FRAME_W-1:0]  r_table;
    logic                           r_new_table;
    logic [tlptm_pkg::OFF_W-1:0]    r_clr_off;
    logic [tlptm_pkg::IDX_W-1:0]    r_clr_cnt;

    logic                           r_out_valid;
    logic [tlptm_pkg::STATUS_W-1:0] r_out_status;
    logic [tlptm_pkg::FRAME_W-1:0]  r_out_frame;
    logic                           r_out_new;
    logic [tlptm_pkg::WORD_W-1:0]   r_out_entry;

    logic [tlptm_pkg::FRAME_W:0]    dir_diff;
    logic [tlptm_pkg::FRAME_W:0]    free_diff;
    logic [tlptm_pkg::FRAME_W:0]    tbl_diff;
    logic [tlptm_pkg::ADDR_W-1:0]   pde_addr;
    logic [tlptm_pkg::ADDR_W-1:0]   wr_addr;
    logic [tlptm_pkg::WORD_W-1:0]   wr_data;
    logic [tlptm_pkg::WORD_W-1:0]   map_entry;
    logic                           wr_en;
    logic                           cfg_fire;

    assign cfg_fire  = i_cfg_valid && o_cfg_ready;
    assign dir_diff  = tlptm_pkg::frame_diff(r_dir_frame, r_window_base);
    assign free_diff = tlptm_pkg::frame_diff(r_next_free, r_window_base);
    assign tbl_diff  = tlptm_pkg::frame_diff(r_table, r_window_base);
    assign pde_addr  = {dir_diff[tlptm_pkg::OFF_W-1:0], r_pd_idx};
    assign map_entry = tlptm_pkg::make_entry(r_phys_frame, r_us, r_rw);

    always_comb begin
        wr_en   = 1'b1;
        wr_addr = pde_addr;
        wr_data = '0;
        unique case (i_cmd.wr)
            tlptm_pkg::WR_NONE: begin
                wr_en = 1'b0;
            end
            tlptm_pkg::WR_CLEAR: begin
                wr_addr = {r_clr_off, r_clr_cnt};
            end
            tlptm_pkg::WR_PDE: begin
                wr_data = tlptm_pkg::make_entry(r_table, r_us, r_rw);
            end
            tlptm_pkg::WR_PTE: begin
                wr_addr = {tbl_diff[tlptm_pkg::OFF_W-1:0], r_pt_idx};
                wr_data = (r_cmd == tlptm_pkg::CMD_MAP) ? map_entry : '0;
            end
            default: begin
                wr_en = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= wr_data;
        end
        if (i_cmd.rd_pde) begin
            r_rd_data <= r_mem[pde_addr];
        end
    end

    // captured fields of the current transaction
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_in) begin
            r_cmd        <= tlptm_pkg::t_cmd'(i_in_cmd);
            r_dir_frame  <= i_in_dir_addr[tlptm_pkg::WORD_W-1:tlptm_pkg::PAGE_SHIFT];
            r_pd_idx     <= i_in_virt_addr[tlptm_pkg::WORD_W-1 -: tlptm_pkg::IDX_W];
            r_pt_idx     <= i_in_virt_addr[tlptm_pkg::PAGE_SHIFT +: tlptm_pkg::IDX_W];
            r_phys_frame <= i_in_phys_addr[tlptm_pkg::WORD_W-1:tlptm_pkg::PAGE_SHIFT];
            r_us         <= i_in_user;
            r_rw         <= i_in_writable;
        end
        if (i_cmd.take_frame) begin
            r_table <= r_next_free;
        end else if (i_cmd.tbl_from_pde) begin
            r_table <= r_rd_data[tlptm_pkg::WORD_W-1:tlptm_pkg::PAGE_SHIFT];
        end
        if (i_cmd.load_in) begin
            r_new_table <= 1'b0;
        end else if (i_cmd.set_new) begin
            r_new_table <= 1'b1;
        end
        if (i_cmd.clr_start) begin
            r_clr_off <= i_cmd.clr_sel_tbl ? free_diff[tlptm_pkg::OFF_W-1:0]
                                           : dir_diff[tlptm_pkg::OFF_W-1:0];
            r_clr_cnt <= '0;
        end else if (i_cmd.wr == tlptm_pkg::WR_CLEAR) begin
            r_clr_cnt <= r_clr_cnt + 1'b1;
        end
    end

    // configuration registers and bump allocator
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_window_base <= tlptm_pkg::WINDOW_BASE_RST;
            r_next_free   <= tlptm_pkg::ALLOC_START_RST;
        end else if (cfg_fire) begin
            unique case (tlptm_pkg::t_cfg_idx'(i_cfg_idx))
                tlptm_pkg::CFG_WINDOW_BASE: r_window_base <= i_cfg_data;
                tlptm_pkg::CFG_ALLOC_START: r_next_free   <= i_cfg_data;
                default: ;
            endcase
        end else if (i_cmd.take_frame) begin
            r_next_free <= r_next_free + 1'b1;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_out_status <= i_cmd.out_status;
            r_out_frame  <= i_cmd.out_frame ? r_table : '0;
            r_out_new    <= r_new_table;
            r_out_entry  <= i_cmd.out_entry ? map_entry : '0;
        end
    end

    assign o_stat.cmd         = r_cmd;
    assign o_stat.dir_ok      = tlptm_pkg::in_window(dir_diff);
    assign o_stat.free_ok     = tlptm_pkg::in_window(free_diff);
    assign o_stat.pde_present = r_rd_data[0];
    assign o_stat.tbl_ok      = tlptm_pkg::in_window(tbl_diff);
    assign o_stat.clr_last    = &r_clr_cnt;
    assign o_stat.out_busy    = r_out_valid && !i_out_ready;

    assign o_cfg_ready     = 1'b1;
    assign o_out_valid     = r_out_valid;
    assign o_out_status    = r_out_status;
    assign o_out_frame     = r_out_frame;
    assign o_out_new_table = r_out_new;
    assign o_out_entry     = r_out_entry;

    a_take_bumps: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.take_frame && !cfg_fire) |=> (r_next_free == $past(r_next_free) + 1'b1))
        else $error("allocator did not advance by one frame");

    a_new_table_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_new) |-> (r_out_status == tlptm_pkg::ST_OK))
        else $error("new table reported with an error status");

endmodule

`default_nettype wire

// ----- rtl/core/tlptm_ctrl.sv -----
// controller state machine: sequences reads, clear sweeps and entry writes
`default_nettype none

module tlptm_ctrl (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_in_valid,
    output logic                      o_in_ready,
    input  wire tlptm_pkg::t_dp_stat  i_stat,
    output tlptm_pkg::t_dp_cmd        o_cmd
);

    tlptm_pkg::t_state  r_state;
    tlptm_pkg::t_state  n_state;
    tlptm_pkg::t_status r_res_status;
    tlptm_pkg::t_status n_res_status;
    logic               r_res_frame;
    logic               n_res_frame;
    logic               r_res_entry;
    logic               n_res_entry;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= tlptm_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        r_res_status <= n_res_status;
        r_res_frame  <= n_res_frame;
        r_res_entry  <= n_res_entry;
    end

    always_comb begin
        n_state      = r_state;
        n_res_status = r_res_status;
        n_res_frame  = r_res_frame;
        n_res_entry  = r_res_entry;
        o_in_ready   = 1'b0;
        o_cmd        = '0;
        o_cmd.wr         = tlptm_pkg::WR_NONE;
        o_cmd.out_status = r_res_status;
        o_cmd.out_frame  = r_res_frame;
        o_cmd.out_entry  = r_res_entry;
        unique case (r_state)
            tlptm_pkg::S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load_in = 1'b1;
                    n_state       = tlptm_pkg::S_EVAL;
                end
            end
            tlptm_pkg::S_EVAL: begin
                n_res_status = tlptm_pkg::ST_OK;
                n_res_frame  = 1'b0;
                n_res_entry  = 1'b0;
                if (i_stat.cmd == tlptm_pkg::CMD_ALLOC) begin
                    if (i_stat.free_ok) begin
                        o_cmd.take_frame = 1'b1;
                        n_res_frame      = 1'b1;
                    end else begin
                        n_res_status = tlptm_pkg::ST_NO_FREE;
                    end
                    n_state = tlptm_pkg::S_FINISH;
                end else if (!i_stat.dir_ok) begin
                    n_res_status = tlptm_pkg::ST_OUTSIDE;
                    n_state      = tlptm_pkg::S_FINISH;
                end else if (i_stat.cmd == tlptm_pkg::CMD_CLR_DIR) begin
                    o_cmd.clr_start = 1'b1;
                    n_state         = tlptm_pkg::S_CLR_DIR;
                end else begin
                    o_cmd.rd_pde = 1'b1;
                    n_state      = tlptm_pkg::S_PDE;
                end
            end
            tlptm_pkg::S_PDE: begin
                if (!i_stat.pde_present && i_stat.cmd == tlptm_pkg::CMD_UNMAP) begin
                    n_res_status = tlptm_pkg::ST_ABSENT;
                    n_state      = tlptm_pkg::S_FINISH;
                end else if (!i_stat.pde_present && !i_stat.free_ok) begin
                    n_res_status = tlptm_pkg::ST_NO_FREE;
                    n_state      = tlptm_pkg::S_FINISH;
                end else if (!i_stat.pde_present) begin
                    // fresh table page: take it, sweep it, then link it in
                    o_cmd.take_frame  = 1'b1;
                    o_cmd.set_new     = 1'b1;
                    o_cmd.clr_start   = 1'b1;
                    o_cmd.clr_sel_tbl = 1'b1;
                    n_state           = tlptm_pkg::S_CLR_TBL;
                end else begin
                    o_cmd.tbl_from_pde = 1'b1;
                    n_state            = tlptm_pkg::S_PTE;
                end
            end
            tlptm_pkg::S_CLR_TBL: begin
                o_cmd.wr = tlptm_pkg::WR_CLEAR;
                if (i_stat.clr_last) begin
                    n_state = tlptm_pkg::S_WR_PDE;
                end
            end
            tlptm_pkg::S_WR_PDE: begin
                o_cmd.wr = tlptm_pkg::WR_PDE;
                n_state  = tlptm_pkg::S_PTE;
            end
            tlptm_pkg::S_PTE: begin
                n_res_frame = 1'b1;
                if (!i_stat.tbl_ok) begin
                    n_res_status = tlptm_pkg::ST_OUTSIDE;
                end else begin
                    o_cmd.wr    = tlptm_pkg::WR_PTE;
                    n_res_entry = (i_stat.cmd == tlptm_pkg::CMD_MAP);
                end
                n_state = tlptm_pkg::S_FINISH;
            end
            tlptm_pkg::S_CLR_DIR: begin
                o_cmd.wr = tlptm_pkg::WR_CLEAR;
                if (i_stat.clr_last) begin
                    n_state = tlptm_pkg::S_FINISH;
                end
            end
            tlptm_pkg::S_FINISH: begin
                if (!i_stat.out_busy) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = tlptm_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = tlptm_pkg::S_IDLE;
            end
        endcase
    end

    a_accept_to_eval: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> (r_state == tlptm_pkg::S_EVAL))
        else $error("accepted transaction did not start evaluation");

    a_sweep_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == tlptm_pkg::S_CLR_TBL && !i_stat.clr_last)
            |=> (r_state == tlptm_pkg::S_CLR_TBL))
        else $error("table clear sweep left early");

    a_load_when_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.out_load |-> !i_stat.out_busy)
        else $error("result loaded over an unread result");

    a_write_in_sweep: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_cmd.wr == tlptm_pkg::WR_CLEAR) |->
            (r_state == tlptm_pkg::S_CLR_TBL || r_state == tlptm_pkg::S_CLR_DIR))
        else $error("clear write outside a sweep");

endmodule

`default_nettype wire

// ----- rtl/core/two_level_page_table_mapper_top.sv -----
// top level: two-level page table mapper with internal page store
// from accept to result load: allocate evaluates, map or unmap with a present directory
// entry reads it then writes the table entry, a new table page adds a 1024-word sweep and
// a directory write, clear directory sweeps 1024 words; the load waits while a result is
// unread; one transaction at a time, the next taken the cycle after the result is loaded
// synchronous active-low reset clears control, window base 39, allocator at 48
`default_nettype none

module two_level_page_table_mapper_top (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    tlptm_in_if.sink   i_req,
    tlptm_out_if.source o_rsp,
    tlptm_cfg_if.sink  i_cfg
);

    tlptm_pkg::t_dp_cmd  cmd;
    tlptm_pkg::t_dp_stat stat;

    tlptm_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_req.valid),
        .o_in_ready (i_req.ready),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    tlptm_dp u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd),
        .o_stat          (stat),
        .i_in_cmd        (i_req.cmd),
        .i_in_dir_addr   (i_req.dir_addr),
        .i_in_virt_addr  (i_req.virt_addr),
        .i_in_phys_addr  (i_req.phys_addr),
        .i_in_user       (i_req.user),
        .i_in_writable   (i_req.writable),
        .i_cfg_valid     (i_cfg.valid),
        .o_cfg_ready     (i_cfg.ready),
        .i_cfg_idx       (i_cfg.idx),
        .i_cfg_data      (i_cfg.data),
        .o_out_valid     (o_rsp.valid),
        .i_out_ready     (o_rsp.ready),
        .o_out_status    (o_rsp.status),
        .o_out_frame     (o_rsp.frame_out),
        .o_out_new_table (o_rsp.new_table),
        .o_out_entry     (o_rsp.entry_word)
    );

endmodule

`default_nettype wire
